@@ rtl/mcod_pkg.sv @@
// ----------------------------------------------------------------------------
// mcod_pkg: shared types and constants for the matrix chain order block
// Request and result payloads, sequencer states, status codes and the
// control bundle that drives the shared arithmetic unit.
// ----------------------------------------------------------------------------
package mcod_pkg;

  localparam int DIM_W    = 12;
  localparam int COST_W   = 40;
  localparam int SPLIT_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int PAIR_W   = 2 * DIM_W;
  localparam int TRIPLE_W = 3 * DIM_W;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_TOO_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] dim_value;
    logic             last_dim;
  } dim_req_t;

  typedef struct packed {
    logic [COST_W-1:0]   min_cost;
    logic [SPLIT_W-1:0]  top_split;
    logic [COUNT_W-1:0]  matrix_count;
    logic [STATUS_W-1:0] status;
  } rslt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_PAB,
    ST_K_RD,
    ST_K_MUL,
    ST_K_CMP,
    ST_FIN
  } state_t;

  // Control bundle for the shared multiply/add/compare unit
  typedef struct packed {
    logic ld_pa;    // capture p[a]
    logic ld_pab;   // form p[a] * p[b+1]
    logic ld_term;  // form split product and partial cost sum
    logic zero_a;   // left sub-chain is a single matrix
    logic zero_b;   // right sub-chain is a single matrix
    logic do_cmp;   // add and compare against running best
    logic first;    // first split of the cell
  } alu_ctl_t;

endpackage

@@ rtl/mcod_dim_ram.sv @@
// ----------------------------------------------------------------------------
// mcod_dim_ram: dimension store
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module mcod_dim_ram #(
  parameter int DEPTH = 17,
  parameter int AW    = 5
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [mcod_pkg::DIM_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [mcod_pkg::DIM_W-1:0] rdata
);
  import mcod_pkg::*;

  logic [DIM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mcod_cost_ram.sv @@
// ----------------------------------------------------------------------------
// mcod_cost_ram: interval cost table
// One write port, two registered read ports (left and right sub-chain).
// ----------------------------------------------------------------------------
module mcod_cost_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [mcod_pkg::COST_W-1:0] wdata,
  input  logic [AW-1:0]               raddr_a,
  input  logic [AW-1:0]               raddr_b,
  output logic [mcod_pkg::COST_W-1:0] rdata_a,
  output logic [mcod_pkg::COST_W-1:0] rdata_b
);
  import mcod_pkg::*;

  logic [COST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/mcod_alu.sv @@
// ----------------------------------------------------------------------------
// mcod_alu: shared arithmetic unit
// Two multipliers, two adders and a comparator, stepped by the sequencer to
// evaluate every split of a cell and keep the cheapest (first on ties).
// ----------------------------------------------------------------------------
module mcod_alu #(
  parameter int IW = 4
) (
  input  logic                        clk,
  input  mcod_pkg::alu_ctl_t          ctl,
  input  logic [mcod_pkg::DIM_W-1:0]  dim_rd,
  input  logic [mcod_pkg::COST_W-1:0] cost_a,
  input  logic [mcod_pkg::COST_W-1:0] cost_b,
  input  logic [IW-1:0]               k_idx,
  output logic [mcod_pkg::COST_W-1:0] best,
  output logic [IW-1:0]               best_k
);
  import mcod_pkg::*;

  logic [DIM_W-1:0]    pa;
  logic [PAIR_W-1:0]   pab;
  logic [TRIPLE_W-1:0] prod;
  logic [COST_W-1:0]   csum;
  logic [COST_W-1:0]   ca;
  logic [COST_W-1:0]   cb;
  logic [COST_W-1:0]   cand;

  // diagonal entries are zero and never stored
  assign ca   = ctl.zero_a ? '0 : cost_a;
  assign cb   = ctl.zero_b ? '0 : cost_b;
  assign cand = csum + COST_W'(prod);

  always_ff @(posedge clk) begin
    if (ctl.ld_pa) begin
      pa <= dim_rd;
    end
    if (ctl.ld_pab) begin
      pab <= PAIR_W'(pa) * PAIR_W'(dim_rd);
    end
    if (ctl.ld_term) begin
      prod <= TRIPLE_W'(pab) * TRIPLE_W'(dim_rd);
      csum <= ca + cb;
    end
    // keep strictly smaller only, so ties hold the earliest split
    if (ctl.do_cmp && (ctl.first || (cand < best))) begin
      best   <= cand;
      best_k <= k_idx;
    end
  end

endmodule

@@ rtl/matrix_chain_order_dp.sv @@
// ----------------------------------------------------------------------------
// matrix_chain_order_dp: minimum-cost matrix chain ordering
// Collects chain dimensions, fills the interval cost table by growing
// sub-chain length with one shared multiply/add/compare unit, and returns
// the least cost, outermost split, matrix count and a status.
//
//   channel  valid       stall       payload  moves
//   request  dim_valid   dim_stall   dim_req  one dimension, last flag
//   result   rslt_valid  rslt_stall  rslt     cost, split, count, status
//
// An unmarked request stores its dimension. A marked one for n >= 2
// matrices runs the fill: per cell, read p[a] and p[b+1]; per split,
// read p[k+1], form the term and compare it in the single cost loop;
// then write the cell, or report the last. Chains with fewer than three
// dimensions or an overflow answer without the fill. rst clears the
// sequencer and counters, not tables. A held result stalls all requests.
// ----------------------------------------------------------------------------
module matrix_chain_order_dp #(
  parameter int MAX_MATRICES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               dim_valid,
  output logic               dim_stall,
  input  mcod_pkg::dim_req_t dim_req,
  output logic               rslt_valid,
  input  logic               rslt_stall,
  output mcod_pkg::rslt_t    rslt
);
  import mcod_pkg::*;

  localparam int DEPTH  = MAX_MATRICES + 1;
  localparam int CDEPTH = MAX_MATRICES * MAX_MATRICES;
  localparam int IW     = $clog2(MAX_MATRICES);
  localparam int DW     = $clog2(DEPTH);
  localparam int NW     = $clog2(MAX_MATRICES + 2);
  localparam int CW     = $clog2(CDEPTH);

  state_t          state, state_next;
  logic [NW-1:0]   dim_count, dim_count_next;
  logic            overflow, overflow_next;
  logic [NW-1:0]   n_mat, n_mat_next;
  logic [IW-1:0]   len, len_next;
  logic [IW-1:0]   a_idx, a_idx_next;
  logic [IW-1:0]   k_idx, k_idx_next;

  logic            accept;
  logic            load_res;
  rslt_t           res_next;
  alu_ctl_t        ctl;
  logic [NW-1:0]   b_ext;
  logic [IW-1:0]   b_idx;
  logic [DW-1:0]   dim_raddr;
  logic [DIM_W-1:0] dim_rd;
  logic            cost_we;
  logic [CW-1:0]   cost_waddr, cost_raddr_a, cost_raddr_b;
  logic [COST_W-1:0] cost_rd_a, cost_rd_b;
  logic [COST_W-1:0] best;
  logic [IW-1:0]   best_k;

  assign b_ext  = NW'(a_idx) + NW'(len);
  assign b_idx  = b_ext[IW-1:0];
  assign accept = dim_valid && !dim_stall;

  // marked requests may produce a result at once, so hold off while full
  assign dim_stall = (state != ST_IDLE) || (rslt_valid && rslt_stall);

  // cost table addressing, row-major
  assign cost_waddr   = CW'(int'(a_idx) * MAX_MATRICES + int'(b_idx));
  assign cost_raddr_a = CW'(int'(a_idx) * MAX_MATRICES + int'(k_idx));
  assign cost_raddr_b = CW'((int'(k_idx) + 1) * MAX_MATRICES + int'(b_idx));

  mcod_dim_ram #(.DEPTH(DEPTH), .AW(DW)) u_dim (
    .clk   (clk),
    .we    (accept && (int'(dim_count) < DEPTH)),
    .waddr (dim_count[DW-1:0]),
    .wdata (dim_req.dim_value),
    .raddr (dim_raddr),
    .rdata (dim_rd)
  );

  mcod_cost_ram #(.DEPTH(CDEPTH), .AW(CW)) u_cost (
    .clk     (clk),
    .we      (cost_we),
    .waddr   (cost_waddr),
    .wdata   (best),
    .raddr_a (cost_raddr_a),
    .raddr_b (cost_raddr_b),
    .rdata_a (cost_rd_a),
    .rdata_b (cost_rd_b)
  );

  mcod_alu #(.IW(IW)) u_alu (
    .clk    (clk),
    .ctl    (ctl),
    .dim_rd (dim_rd),
    .cost_a (cost_rd_a),
    .cost_b (cost_rd_b),
    .k_idx  (k_idx),
    .best   (best),
    .best_k (best_k)
  );

  // sequencer state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dim_count <= '0;
      overflow  <= 1'b0;
      n_mat     <= '0;
      len       <= '0;
      a_idx     <= '0;
      k_idx     <= '0;
    end else begin
      state     <= state_next;
      dim_count <= dim_count_next;
      overflow  <= overflow_next;
      n_mat     <= n_mat_next;
      len       <= len_next;
      a_idx     <= a_idx_next;
      k_idx     <= k_idx_next;
    end
  end

  // next state, unit control and result assembly
  always_comb begin
    state_next     = state;
    dim_count_next = dim_count;
    overflow_next  = overflow;
    n_mat_next     = n_mat;
    len_next       = len;
    a_idx_next     = a_idx;
    k_idx_next     = k_idx;
    ctl            = '0;
    dim_raddr      = '0;
    cost_we        = 1'b0;
    load_res       = 1'b0;
    res_next       = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (int'(dim_count) < DEPTH) begin
            dim_count_next = dim_count + 1'b1;
          end else begin
            overflow_next = 1'b1;
          end
          if (dim_req.last_dim) begin
            dim_count_next = '0;
            overflow_next  = 1'b0;
            if (overflow || (int'(dim_count) >= DEPTH)) begin
              load_res        = 1'b1;
              res_next.status = STAT_OVERFLOW;
            end else if (dim_count == '0) begin
              load_res        = 1'b1;
              res_next.status = STAT_TOO_FEW;
            end else if (dim_count == NW'(1)) begin
              // single matrix: no multiplications
              load_res              = 1'b1;
              res_next.matrix_count = COUNT_W'(1);
              res_next.status       = STAT_OK;
            end else begin
              n_mat_next = dim_count;
              len_next   = IW'(1);
              a_idx_next = '0;
              state_next = ST_RD_A;
            end
          end
        end
      end
      ST_RD_A: begin
        dim_raddr  = DW'(a_idx);
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        ctl.ld_pa  = 1'b1;
        dim_raddr  = DW'(b_ext + 1'b1);
        state_next = ST_PAB;
      end
      ST_PAB: begin
        ctl.ld_pab = 1'b1;
        k_idx_next = a_idx;
        state_next = ST_K_RD;
      end
      ST_K_RD: begin
        dim_raddr  = DW'(NW'(k_idx) + 1'b1);
        state_next = ST_K_MUL;
      end
      ST_K_MUL: begin
        ctl.ld_term = 1'b1;
        ctl.zero_a  = (k_idx == a_idx);
        ctl.zero_b  = (NW'(k_idx) + 1'b1 == b_ext);
        state_next  = ST_K_CMP;
      end
      ST_K_CMP: begin
        ctl.do_cmp = 1'b1;
        ctl.first  = (k_idx == a_idx);
        if (NW'(k_idx) + 1'b1 == b_ext) begin
          state_next = ST_FIN;
        end else begin
          k_idx_next = k_idx + 1'b1;
          state_next = ST_K_RD;
        end
      end
      ST_FIN: begin
        // cell done: store it and move on, or report the final cell once the result register is free
        if (b_ext + 1'b1 < n_mat) begin
          cost_we    = 1'b1;
          a_idx_next = a_idx + 1'b1;
          state_next = ST_RD_A;
        end else if (NW'(len) + 1'b1 < n_mat) begin
          cost_we    = 1'b1;
          len_next   = len + 1'b1;
          a_idx_next = '0;
          state_next = ST_RD_A;
        end else if (!rslt_valid || !rslt_stall) begin
          load_res              = 1'b1;
          res_next.min_cost     = best;
          res_next.top_split    = SPLIT_W'(best_k);
          res_next.matrix_count = COUNT_W'(n_mat);
          res_next.status       = STAT_OK;
          state_next            = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rslt_valid <= 1'b0;
    end else if (load_res) begin
      rslt_valid <= 1'b1;
    end else if (!rslt_stall) begin
      rslt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      rslt <= res_next;
    end
  end

  // a split scan never runs past the end of its cell
  a_k_in_cell: assert property (@(posedge clk) disable iff (rst)
    (state == ST_K_CMP) |-> (NW'(k_idx) < b_ext))
    else $error("split index outside cell");

  // cells stay inside the chain
  a_cell_in_chain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_A) |-> (b_ext < n_mat))
    else $error("cell beyond chain end");

  // error results carry no cost
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rslt_valid && (rslt.status != STAT_OK)) |-> (rslt.min_cost == '0))
    else $error("error result with nonzero cost");

  // a new result never overwrites one still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rslt_valid && rslt_stall) |-> !load_res)
    else $error("result overwritten while stalled");

endmodule
